// ----- design/mvt_pkg.sv -----
// mvt_pkg: shared constants, selector codes and pipeline control type for the
// 4x4 matrix-vector transform unit. No dependencies.
`default_nettype none

package mvt_pkg;

  localparam int DIM               = 4;
  localparam int ENTRIES           = DIM * DIM;
  localparam int IDX_BITS          = 4;
  localparam int FIELD_BITS        = 32;
  localparam int FRAC_SHIFT        = 16;
  localparam int DEFAULT_WORD_BITS = 32;

  localparam int FUNC_BITS     = 2;
  localparam int IN_DATA_BITS  = 168;  // 164 bits of fields, padded to bytes
  localparam int OUT_DATA_BITS = DIM * FIELD_BITS;

  typedef enum logic [FUNC_BITS-1:0] {
    FUNC_LOAD    = 2'd0,
    FUNC_COL_XFM = 2'd1,
    FUNC_ROW_XFM = 2'd2,
    FUNC_NOP     = 2'd3
  } func_t;

  typedef struct packed {
    logic prod_en;  // product stage loads
    logic sum_en;   // sum/saturate stage loads
  } pipe_ctrl_t;

endpackage

`default_nettype wire

// ----- design/matrix4_vector_transform_unit.sv -----
// matrix4_vector_transform_unit: top level. Matrix registers, row/column
// operand select, four lanes and the merge/output stage.
// Depends on mvt_pkg, mvt_lane, mvt_merge.
//
//   channel  dir  tdata                              tuser
//   in_      in   index, value, x, y, z, w (168b)    func (2b)
//   out_     out  res x, y, z, w (128b)              overflow (1b)
//
// One beat per cycle sustained while the output is not stalled; a transform result
// passes the product register, the sum/saturate register and the output register.
// Load beats write the matrix at acceptance and are seen by the next beat.
// Reset clears the matrix and all stage valids; each stage advances when the
// one after it is empty or moving, so a stalled output backs up stage by stage.
`default_nettype none

module matrix4_vector_transform_unit #(
  parameter int WORD_BITS = mvt_pkg::DEFAULT_WORD_BITS
) (
  input  wire                                clk,
  input  wire                                rst_n,
  input  wire                                in_tvalid,
  output logic                               in_tready,
  // [3:0] entry_index, [35:4] entry_value, [67:36] vec_x, [99:68] vec_y,
  // [131:100] vec_z, [163:132] vec_w, [167:164] zero
  input  wire [mvt_pkg::IN_DATA_BITS-1:0]    in_tdata,
  // [1:0] func
  input  wire [mvt_pkg::FUNC_BITS-1:0]       in_tuser,
  output logic                               out_tvalid,
  input  wire                                out_tready,
  // [31:0] res_x, [63:32] res_y, [95:64] res_z, [127:96] res_w
  output logic [mvt_pkg::OUT_DATA_BITS-1:0]  out_tdata,
  // [0] overflow
  output logic [0:0]                         out_tuser
);
  import mvt_pkg::*;

  localparam int VAL_LSB = IDX_BITS;
  localparam int VEC_LSB = IDX_BITS + FIELD_BITS;
  localparam logic [FIELD_BITS-1:0] SAT_MAX =
    FIELD_BITS'(signed'({1'b0, {(WORD_BITS-1){1'b1}}}));
  localparam logic [FIELD_BITS-1:0] SAT_MIN =
    FIELD_BITS'(signed'({1'b1, {(WORD_BITS-1){1'b0}}}));

  logic signed [WORD_BITS-1:0] mat_r [ENTRIES];
  logic signed [WORD_BITS-1:0] vec   [DIM];
  logic signed [WORD_BITS-1:0] opnd  [DIM][DIM];
  logic signed [WORD_BITS-1:0] lane_res [DIM];
  logic [DIM-1:0]              lane_sat;

  func_t      func;
  logic       in_beat;
  logic       xfm_beat;
  logic       v1_r, v2_r, v3_r;
  logic       rdy1, rdy2, rdy3;
  pipe_ctrl_t ctrl;

  assign func     = func_t'(in_tuser);
  assign in_beat  = in_tvalid && in_tready;
  assign xfm_beat = in_beat && (func == FUNC_COL_XFM || func == FUNC_ROW_XFM);

  assign rdy3      = !v3_r || out_tready;
  assign rdy2      = !v2_r || rdy3;
  assign rdy1      = !v1_r || rdy2;
  assign in_tready = rdy1;

  assign ctrl.prod_en = rdy1;
  assign ctrl.sum_en  = rdy2;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else begin
      if (rdy1) v1_r <= xfm_beat;
      if (rdy2) v2_r <= v1_r;
      if (rdy3) v3_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < ENTRIES; k++) begin
        mat_r[k] <= '0;
      end
    end else if (in_beat && func == FUNC_LOAD) begin
      mat_r[in_tdata[IDX_BITS-1:0]] <= in_tdata[VAL_LSB +: WORD_BITS];
    end
  end

  // lane i element j: row i for column transform, column i for row transform
  always_comb begin
    for (int j = 0; j < DIM; j++) begin
      vec[j] = in_tdata[VEC_LSB + j*FIELD_BITS +: WORD_BITS];
    end
    for (int i = 0; i < DIM; i++) begin
      for (int j = 0; j < DIM; j++) begin
        opnd[i][j] = (func == FUNC_ROW_XFM) ? mat_r[j*DIM + i] : mat_r[i*DIM + j];
      end
    end
  end

  for (genvar g = 0; g < DIM; g++) begin : g_lane
    mvt_lane #(.WORD_BITS(WORD_BITS)) u_lane (
      .clk   (clk),
      .ctrl  (ctrl),
      .mat_i (opnd[g]),
      .vec_i (vec),
      .res_o (lane_res[g]),
      .sat_o (lane_sat[g])
    );
  end

  mvt_merge #(.WORD_BITS(WORD_BITS)) u_merge (
    .clk    (clk),
    .load_i (rdy3),
    .res_i  (lane_res),
    .sat_i  (lane_sat),
    .data_o (out_tdata),
    .ovf_o  (out_tuser[0])
  );

  assign out_tvalid = v3_r;

  // overflow beat must carry at least one clamped component
  a_ovf_clamped: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tuser[0]) |->
      (out_tdata[31:0] == SAT_MAX || out_tdata[31:0] == SAT_MIN ||
       out_tdata[63:32] == SAT_MAX || out_tdata[63:32] == SAT_MIN ||
       out_tdata[95:64] == SAT_MAX || out_tdata[95:64] == SAT_MIN ||
       out_tdata[127:96] == SAT_MAX || out_tdata[127:96] == SAT_MIN))
    else $error("overflow set without a saturated component");

  a_load_no_result: assert property (@(posedge clk) disable iff (!rst_n)
    (in_beat && func == FUNC_LOAD) |=> !v1_r)
    else $error("load beat entered the pipeline");

  a_full_stall: assert property (@(posedge clk) disable iff (!rst_n)
    (v1_r && v2_r && v3_r && !out_tready) |-> !in_tready)
    else $error("input taken while pipeline full and stalled");

endmodule

`default_nettype wire

// ----- design/mvt_lane.sv -----
// mvt_lane: one result component. Four registered products, then the
// four-way sum with saturation, registered. Depends on mvt_pkg.
`default_nettype none

module mvt_lane #(
  parameter int WORD_BITS = mvt_pkg::DEFAULT_WORD_BITS
) (
  input  wire                             clk,
  input  wire mvt_pkg::pipe_ctrl_t        ctrl,
  input  wire logic signed [WORD_BITS-1:0] mat_i [mvt_pkg::DIM],
  input  wire logic signed [WORD_BITS-1:0] vec_i [mvt_pkg::DIM],
  output logic signed [WORD_BITS-1:0]      res_o,
  output logic                             sat_o
);
  import mvt_pkg::*;

  localparam int PROD_BITS = 2 * WORD_BITS;
  localparam int SHFT_BITS = PROD_BITS - FRAC_SHIFT;
  localparam int SUM_BITS  = SHFT_BITS + 2;

  logic signed [PROD_BITS-1:0] prod_r [DIM];
  logic signed [SUM_BITS-1:0]  sum;
  logic signed [WORD_BITS-1:0] res_nxt;
  logic                        sat_nxt;
  logic signed [WORD_BITS-1:0] res_r;
  logic                        sat_r;

  always_ff @(posedge clk) begin
    if (ctrl.prod_en) begin
      for (int j = 0; j < DIM; j++) begin
        prod_r[j] <= PROD_BITS'(mat_i[j]) * PROD_BITS'(vec_i[j]);
      end
    end
  end

  // floor shift by FRAC_SHIFT is a plain part-select of the product
  always_comb begin
    sum = '0;
    for (int j = 0; j < DIM; j++) begin
      sum = sum + SUM_BITS'(signed'(prod_r[j][PROD_BITS-1:FRAC_SHIFT]));
    end
    sat_nxt = 1'b0;
    res_nxt = sum[WORD_BITS-1:0];
    if (!sum[SUM_BITS-1] && (sum[SUM_BITS-2:WORD_BITS-1] != '0)) begin
      sat_nxt = 1'b1;
      res_nxt = {1'b0, {(WORD_BITS-1){1'b1}}};
    end else if (sum[SUM_BITS-1] && (sum[SUM_BITS-2:WORD_BITS-1] != '1)) begin
      sat_nxt = 1'b1;
      res_nxt = {1'b1, {(WORD_BITS-1){1'b0}}};
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.sum_en) begin
      res_r <= res_nxt;
      sat_r <= sat_nxt;
    end
  end

  assign res_o = res_r;
  assign sat_o = sat_r;

endmodule

`default_nettype wire

// ----- design/mvt_merge.sv -----
// mvt_merge: output register. Sign-extends the lane results into the result
// beat and ORs the lane saturation flags. Depends on mvt_pkg.
`default_nettype none

module mvt_merge #(
  parameter int WORD_BITS = mvt_pkg::DEFAULT_WORD_BITS
) (
  input  wire                                   clk,
  input  wire                                   load_i,
  input  wire logic signed [WORD_BITS-1:0]      res_i [mvt_pkg::DIM],
  input  wire logic [mvt_pkg::DIM-1:0]          sat_i,
  output logic [mvt_pkg::OUT_DATA_BITS-1:0]     data_o,
  output logic                                  ovf_o
);
  import mvt_pkg::*;

  logic [OUT_DATA_BITS-1:0] data_r;
  logic [OUT_DATA_BITS-1:0] data_nxt;
  logic                     ovf_r;

  always_comb begin
    for (int i = 0; i < DIM; i++) begin
      data_nxt[i*FIELD_BITS +: FIELD_BITS] = FIELD_BITS'(res_i[i]);
    end
  end

  always_ff @(posedge clk) begin
    if (load_i) begin
      data_r <= data_nxt;
      ovf_r  <= |sat_i;
    end
  end

  assign data_o = data_r;
  assign ovf_o  = ovf_r;

endmodule

`default_nettype wire
